@@ sv/ucc_pkg.sv @@
// Shared types and constants for the UTF-8 character counter.
package ucc_pkg;

    // Width of the character and byte counters; they wrap at this width.
    localparam int COUNT_WIDTH = 32;
    localparam int LIMIT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COUNT_LIMIT_EN = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COUNT_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BYTE_LIMIT_EN  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BYTE_LIMIT     = 2'd3;

    // Lead and continuation byte patterns.
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] TWO_MASK   = 8'he0;
    localparam logic [7:0] TWO_TAG    = 8'hc0;
    localparam logic [7:0] THREE_MASK = 8'hf0;
    localparam logic [7:0] THREE_TAG  = 8'he0;
    localparam logic [7:0] FOUR_MASK  = 8'hf8;
    localparam logic [7:0] FOUR_TAG   = 8'hf0;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_SEQ  = 2'd1,
        PH_SKIP = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic                   count_limit_enable;
        logic [LIMIT_WIDTH-1:0] count_limit;
        logic                   byte_limit_enable;
        logic [LIMIT_WIDTH-1:0] byte_limit;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [1:0]             pending;
        logic [COUNT_WIDTH-1:0] chars;
        logic [COUNT_WIDTH-1:0] bytes;
    } scan_state_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_WIDTH-1:0] char_total;
        logic [OUT_WIDTH-1:0] stop_offset;
    } result_t;

    localparam scan_state_t SCAN_CLEAR = '{
        phase:   PH_LEAD,
        pending: 2'd0,
        chars:   '0,
        bytes:   '0
    };

endpackage

@@ sv/ucc_cfg_regs.sv @@
// Configuration register file for the UTF-8 character counter.
module ucc_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ucc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ucc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output ucc_pkg::cfg_t                        cfg
);
    import ucc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNT_LIMIT_EN: cfg_next.count_limit_enable = cfg_data[0];
                REG_COUNT_LIMIT:    cfg_next.count_limit = LIMIT_WIDTH'(cfg_data);
                REG_BYTE_LIMIT_EN:  cfg_next.byte_limit_enable = cfg_data[0];
                REG_BYTE_LIMIT:     cfg_next.byte_limit = LIMIT_WIDTH'(cfg_data);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/ucc_step.sv @@
// Per-byte decode: lead classification, continuation check, limits and counter update.
module ucc_step (
    input  ucc_pkg::cfg_t        cfg,
    input  ucc_pkg::scan_state_t cur,
    input  logic [7:0]           text_byte,
    output ucc_pkg::scan_state_t nxt,
    output logic                 emit,
    output ucc_pkg::result_t     res
);
    import ucc_pkg::*;

    logic [CMP_WIDTH-1:0] chars_cmp;
    logic [CMP_WIDTH-1:0] bytes_cmp;
    logic                 is_nul;
    logic                 cnt_hit;
    logic                 byte_hit;
    logic                 short_str;
    logic [2:0]           lead_len;

    assign chars_cmp = CMP_WIDTH'(cur.chars);
    assign bytes_cmp = CMP_WIDTH'(cur.bytes);
    assign is_nul    = (text_byte == 8'h00);
    assign cnt_hit   = cfg.count_limit_enable && (chars_cmp == CMP_WIDTH'(cfg.count_limit));
    assign byte_hit  = cfg.byte_limit_enable && (bytes_cmp >= CMP_WIDTH'(cfg.byte_limit));
    assign short_str = cfg.count_limit_enable && (cfg.count_limit != '0)
                       && (chars_cmp != CMP_WIDTH'(cfg.count_limit));

    // Sequence length from the high bits of a lead byte; zero marks an invalid lead.
    always_comb
    begin
        if ((text_byte & ASCII_MASK) == 8'h00)
            lead_len = 3'd1;
        else if ((text_byte & TWO_MASK) == TWO_TAG)
            lead_len = 3'd2;
        else if ((text_byte & THREE_MASK) == THREE_TAG)
            lead_len = 3'd3;
        else if ((text_byte & FOUR_MASK) == FOUR_TAG)
            lead_len = 3'd4;
        else
            lead_len = 3'd0;
    end

    always_comb
    begin
        nxt              = cur;
        emit             = 1'b0;
        res.status       = ST_OK;
        res.char_total   = '0;
        res.stop_offset  = OUT_WIDTH'(cur.bytes);
        case (cur.phase)
            PH_SKIP:
            begin
                if (is_nul)
                    nxt = SCAN_CLEAR;
            end
            PH_SEQ:
            begin
                if ((text_byte & CONT_MASK) != CONT_TAG)
                begin
                    emit       = 1'b1;
                    res.status = ST_BAD;
                    nxt        = SCAN_CLEAR;
                    nxt.phase  = is_nul ? PH_LEAD : PH_SKIP;
                end
                else
                begin
                    nxt.bytes = cur.bytes + COUNT_WIDTH'(1);
                    if (cur.pending > 2'd1)
                    begin
                        nxt.pending = cur.pending - 2'd1;
                    end
                    else
                    begin
                        nxt.pending = 2'd0;
                        nxt.chars   = cur.chars + COUNT_WIDTH'(1);
                        nxt.phase   = PH_LEAD;
                    end
                end
            end
            PH_LEAD:
            begin
                if (is_nul || cnt_hit || byte_hit)
                begin
                    emit = 1'b1;
                    if (short_str)
                    begin
                        res.status = ST_SHORT;
                    end
                    else
                    begin
                        res.status     = ST_OK;
                        res.char_total = OUT_WIDTH'(cur.chars);
                    end
                    nxt       = SCAN_CLEAR;
                    nxt.phase = is_nul ? PH_LEAD : PH_SKIP;
                end
                else if (lead_len == 3'd0)
                begin
                    emit       = 1'b1;
                    res.status = ST_BAD;
                    nxt        = SCAN_CLEAR;
                    nxt.phase  = PH_SKIP;
                end
                else
                begin
                    nxt.bytes = cur.bytes + COUNT_WIDTH'(1);
                    if (lead_len == 3'd1)
                    begin
                        nxt.chars = cur.chars + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        nxt.pending = 2'(lead_len - 3'd1);
                        nxt.phase   = PH_SEQ;
                    end
                end
            end
            default:
            begin
                nxt = SCAN_CLEAR;
            end
        endcase
    end

endmodule

@@ sv/utf8_char_counter_core.sv @@
// UTF-8 validator and character counter, top level.
// Throughput: one byte per cycle; the input register takes a new request every cycle
// as long as the result register is free or being drained.
// An accepted byte is held in the input register and decoded from it; its result, if any,
// is captured in the output register, which holds it while stalled.
// Reset clears the scan state, counters, configuration and both valid flags.
module utf8_char_counter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ucc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ucc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           text_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic [ucc_pkg::OUT_WIDTH-1:0]        char_total,
    output logic [ucc_pkg::OUT_WIDTH-1:0]        stop_offset
);
    import ucc_pkg::*;

    cfg_t        cfg;
    scan_state_t state_reg;
    scan_state_t state_next;
    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        out_vld_reg;
    result_t     res_reg;
    result_t     step_res;
    logic        step_emit;
    logic        advance;

    ucc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ucc_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .text_byte (byte_reg),
        .nxt       (state_next),
        .emit      (step_emit),
        .res       (step_res)
    );

    // The held byte moves on once the result register is empty or being emptied.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= SCAN_CLEAR;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                state_reg <= state_next;
            if (advance && step_emit)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= text_byte;
        if (advance && step_emit)
            res_reg <= step_res;
    end

    assign out_valid   = out_vld_reg;
    assign status      = res_reg.status;
    assign char_total  = res_reg.char_total;
    assign stop_offset = res_reg.stop_offset;

    a_seq_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_SEQ |-> state_reg.pending != 2'd0)
        else $error("inside a sequence with no continuation pending");

    a_lead_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_SEQ |-> state_reg.pending == 2'd0)
        else $error("pending continuations outside a sequence");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.status != ST_OK |-> res_reg.char_total == '0)
        else $error("character total not zero on a failed string");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_emit |=> out_vld_reg)
        else $error("emitted result was not registered");

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.phase == PH_SKIP |-> !step_emit)
        else $error("result produced while skipping to the terminator");

endmodule
